[hw/rtl/scsa_pkg.sv]
// Shared types, constants and helper functions of the slab allocator.
package scsa_pkg;

  localparam int unsigned Pages       = 16;
  localparam int unsigned UsablePages = (Pages < 16) ? Pages : 16;
  localparam int unsigned SizeClasses = 7;
  localparam int unsigned ClassLimit  = 7;
  localparam int unsigned PageW       = 4;
  localparam int unsigned SlotW       = 7;
  localparam int unsigned StepW       = 5;
  localparam int unsigned MinShift    = 5;
  localparam logic [12:0] MaxBytes    = 13'd2048;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_LARGE   = 3'd2,
    ST_NOPAGE  = 3'd3,
    ST_BADFREE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CLAIM, S_CLAIM_FIN, S_WALK_LOAD, S_WALK, S_POP, S_RESP
  } state_e;

  typedef struct packed {
    logic    latch_req;
    logic    claim_start;
    logic    claim_step;
    logic    claim_fin;
    logic    walk_load;
    logic    walk_next;
    logic    walk_read;
    logic    pop_commit;
    logic    free_commit;
    logic    res_we;
    status_e res_status;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic    is_free;
    status_e dec_status;
    logic    need_claim;
    logic    pages_full;
    logic    free_bad;
    logic    claim_last;
    logic    cur_vld;
    logic    walk_done;
    logic    cur_has_free;
    logic    out_busy;
  } stat_t;

  // Free slots of a wholly free page of class c (slot 0 is reserved).
  function automatic logic [6:0] slots_whole(input logic [2:0] c);
    logic [7:0] v;
    v = (8'd128 >> c) - 8'd1;
    return v[6:0];
  endfunction

  // Smallest power-of-two class of 32 << c bytes that holds s.
  function automatic logic [2:0] size_class(input logic [12:0] s);
    logic [2:0] c;
    c = 3'd6;
    for (int i = 6; i >= 0; i--) begin
      if (s <= (13'd32 << i)) c = 3'(i);
    end
    return c;
  endfunction

endpackage

[hw/rtl/scsa_ctrl.sv]
// Sequencer of the slab allocator: decides the steps of each request.
module scsa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  scsa_pkg::stat_t stat_i,
  output scsa_pkg::cmd_t  cmd_o
);

  scsa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scsa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.res_status = scsa_pkg::ST_OK;
    in_ready_o = 1'b0;
    case (state_q)
      scsa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d = scsa_pkg::S_DECODE;
        end
      end
      scsa_pkg::S_DECODE: begin
        if (stat_i.is_free) begin
          cmd_o.res_we = 1'b1;
          if (stat_i.free_bad) begin
            cmd_o.res_status = scsa_pkg::ST_BADFREE;
          end else begin
            cmd_o.free_commit = 1'b1;
          end
          state_d = scsa_pkg::S_RESP;
        end else if (stat_i.dec_status != scsa_pkg::ST_OK) begin
          cmd_o.res_we = 1'b1;
          cmd_o.res_status = stat_i.dec_status;
          state_d = scsa_pkg::S_RESP;
        end else if (stat_i.need_claim && stat_i.pages_full) begin
          cmd_o.res_we = 1'b1;
          cmd_o.res_status = scsa_pkg::ST_NOPAGE;
          state_d = scsa_pkg::S_RESP;
        end else if (stat_i.need_claim) begin
          cmd_o.claim_start = 1'b1;
          state_d = scsa_pkg::S_CLAIM;
        end else begin
          state_d = scsa_pkg::S_WALK_LOAD;
        end
      end
      scsa_pkg::S_CLAIM: begin
        cmd_o.claim_step = 1'b1;
        if (stat_i.claim_last) state_d = scsa_pkg::S_CLAIM_FIN;
      end
      scsa_pkg::S_CLAIM_FIN: begin
        cmd_o.claim_fin = 1'b1;
        state_d = scsa_pkg::S_WALK_LOAD;
      end
      scsa_pkg::S_WALK_LOAD: begin
        cmd_o.walk_load = 1'b1;
        state_d = scsa_pkg::S_WALK;
      end
      scsa_pkg::S_WALK: begin
        if (!stat_i.cur_vld || stat_i.walk_done) begin
          cmd_o.res_we = 1'b1;
          cmd_o.res_status = scsa_pkg::ST_NOPAGE;
          state_d = scsa_pkg::S_RESP;
        end else if (stat_i.cur_has_free) begin
          cmd_o.walk_read = 1'b1;
          state_d = scsa_pkg::S_POP;
        end else begin
          cmd_o.walk_next = 1'b1;
        end
      end
      scsa_pkg::S_POP: begin
        cmd_o.pop_commit = 1'b1;
        cmd_o.res_we = 1'b1;
        state_d = scsa_pkg::S_RESP;
      end
      scsa_pkg::S_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d = scsa_pkg::S_IDLE;
        end
      end
      default: state_d = scsa_pkg::S_IDLE;
    endcase
  end

endmodule

[hw/rtl/scsa_dpath.sv]
// Datapath of the slab allocator: class and page tables, slot link memory,
// result and output registers.
module scsa_dpath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_type_i,
  input  logic [12:0]     req_size_i,
  input  logic [15:0]     free_address_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [2:0]      status_o,
  output logic [15:0]     object_address_o,
  input  scsa_pkg::cmd_t  cmd_i,
  output scsa_pkg::stat_t stat_o
);

  localparam int unsigned PW = scsa_pkg::PageW;
  localparam int unsigned SW = scsa_pkg::SlotW;
  localparam int unsigned TW = scsa_pkg::StepW;
  localparam int unsigned NC = scsa_pkg::SizeClasses;
  localparam int unsigned NP = scsa_pkg::Pages;

  // Request registers
  logic        req_type_q;
  logic [12:0] req_size_q;
  logic [15:0] free_addr_q;
  logic [2:0]  cls_q;

  // Class tables
  logic [PW-1:0] class_head_q [NC];
  logic [NC-1:0] class_head_vld_q;
  logic [10:0]   class_free_q [NC];
  logic [4:0]    class_whole_q [NC];
  logic [4:0]    pages_claimed_q;

  // Page tables, undefined until written
  logic [PW-1:0] page_next_q [NP];
  logic [NP-1:0] page_next_vld_q;
  logic [2:0]    page_class_q [NP];
  logic [SW-1:0] page_cnt_q [NP];
  logic [SW-1:0] page_head_q [NP];

  // Slot link memory, one row of slots per page
  logic [SW-1:0] slot_link_mem [NP * (1 << SW)];
  logic [SW-1:0] link_rd_q;

  // Walk and fill registers
  logic [PW-1:0]  cur_page_q;
  logic           cur_vld_q;
  logic [TW-1:0]  steps_q;
  logic [SW-1:0]  slot_ctr_q;
  logic [SW-1:0]  build_head_q;
  logic [SW-1:0]  pop_slot_q;
  logic [PW-1:0]  new_page_q;

  // Result and output
  logic [2:0]  res_status_q;
  logic [15:0] res_addr_q;
  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic [15:0] out_addr_q;

  logic [SW-1:0] n_cls;
  logic [PW-1:0] fp;
  logic [11:0]   foff;
  logic [2:0]    fcls;
  logic [SW-1:0] fn;
  logic [11:0]   fmask;
  logic [SW-1:0] fslot;
  logic          fbad;
  logic [15:0]   pop_addr;
  logic [15:0]   slot_off;
  logic [SW-1:0] cnt_cur;

  assign n_cls   = scsa_pkg::slots_whole(cls_q);
  assign fp      = free_addr_q[15:12];
  assign foff    = free_addr_q[11:0];
  assign fcls    = page_class_q[fp];
  assign fn      = scsa_pkg::slots_whole(fcls);
  assign fmask   = (12'd32 << fcls) - 12'd1;
  assign fslot   = SW'(foff >> (4'(scsa_pkg::MinShift) + 4'(fcls)));
  assign cnt_cur = page_cnt_q[cur_page_q];
  assign slot_off = 16'(pop_slot_q) << (4'(scsa_pkg::MinShift) + 4'(cls_q));
  assign pop_addr = {cur_page_q, 12'd0} + slot_off;

  always_comb begin
    fbad = 1'b0;
    if ({1'b0, fp} >= pages_claimed_q) fbad = 1'b1;
    else if (32'(fcls) >= scsa_pkg::SizeClasses || 32'(fcls) >= scsa_pkg::ClassLimit) fbad = 1'b1;
    else if ((foff & fmask) != 12'd0) fbad = 1'b1;
    else if (fslot == '0 || page_cnt_q[fp] >= fn) fbad = 1'b1;
  end

  always_comb begin
    stat_o.is_free = req_type_q;
    if (req_size_q == 13'd0) stat_o.dec_status = scsa_pkg::ST_ZERO;
    else if (req_size_q > scsa_pkg::MaxBytes) stat_o.dec_status = scsa_pkg::ST_LARGE;
    else if (32'(cls_q) >= scsa_pkg::SizeClasses || 32'(cls_q) >= scsa_pkg::ClassLimit)
      stat_o.dec_status = scsa_pkg::ST_LARGE;
    else stat_o.dec_status = scsa_pkg::ST_OK;
    stat_o.need_claim   = (class_free_q[cls_q] == 11'd0);
    stat_o.pages_full   = (32'(pages_claimed_q) >= scsa_pkg::UsablePages);
    stat_o.free_bad     = fbad;
    stat_o.claim_last   = (slot_ctr_q == n_cls);
    stat_o.cur_vld      = cur_vld_q;
    stat_o.walk_done    = (32'(steps_q) >= NP);
    stat_o.cur_has_free = (cnt_cur != '0);
    stat_o.out_busy     = out_valid_q && !out_ready_i;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_head_vld_q <= '0;
      pages_claimed_q  <= '0;
      out_valid_q      <= 1'b0;
      for (int i = 0; i < NC; i++) begin
        class_free_q[i]  <= '0;
        class_whole_q[i] <= '0;
        class_head_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.claim_fin) begin
        class_head_q[cls_q]     <= new_page_q;
        class_head_vld_q[cls_q] <= 1'b1;
        class_whole_q[cls_q]    <= class_whole_q[cls_q] + 5'd1;
        class_free_q[cls_q]     <= class_free_q[cls_q] + 11'(n_cls);
        pages_claimed_q         <= pages_claimed_q + 5'd1;
      end
      if (cmd_i.pop_commit) begin
        if (class_free_q[cls_q] != '0) class_free_q[cls_q] <= class_free_q[cls_q] - 11'd1;
        if (cnt_cur == n_cls && class_whole_q[cls_q] != '0)
          class_whole_q[cls_q] <= class_whole_q[cls_q] - 5'd1;
      end
      if (cmd_i.free_commit) begin
        class_free_q[fcls] <= class_free_q[fcls] + 11'd1;
        if (page_cnt_q[fp] + SW'(1) == fn) class_whole_q[fcls] <= class_whole_q[fcls] + 5'd1;
      end
    end
  end

  // Payload registers and page tables
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_type_q  <= req_type_i;
      req_size_q  <= req_size_i;
      free_addr_q <= free_address_i;
      cls_q       <= scsa_pkg::size_class(req_size_i);
    end
    if (cmd_i.claim_start) begin
      slot_ctr_q   <= SW'(1);
      build_head_q <= '0;
      new_page_q   <= pages_claimed_q[PW-1:0];
    end
    if (cmd_i.claim_step) begin
      build_head_q <= slot_ctr_q;
      slot_ctr_q   <= slot_ctr_q + SW'(1);
    end
    if (cmd_i.claim_fin) begin
      page_class_q[new_page_q]    <= cls_q;
      page_head_q[new_page_q]     <= build_head_q;
      page_cnt_q[new_page_q]      <= n_cls;
      page_next_q[new_page_q]     <= class_head_q[cls_q];
      page_next_vld_q[new_page_q] <= class_head_vld_q[cls_q];
    end
    if (cmd_i.walk_load) begin
      cur_page_q <= class_head_q[cls_q];
      cur_vld_q  <= class_head_vld_q[cls_q];
      steps_q    <= '0;
    end
    if (cmd_i.walk_next) begin
      cur_page_q <= page_next_q[cur_page_q];
      cur_vld_q  <= page_next_vld_q[cur_page_q];
      steps_q    <= steps_q + TW'(1);
    end
    if (cmd_i.walk_read) pop_slot_q <= page_head_q[cur_page_q];
    if (cmd_i.pop_commit) begin
      page_head_q[cur_page_q] <= link_rd_q;
      page_cnt_q[cur_page_q]  <= cnt_cur - SW'(1);
    end
    if (cmd_i.free_commit) begin
      page_head_q[fp] <= fslot;
      page_cnt_q[fp]  <= page_cnt_q[fp] + SW'(1);
    end
    if (cmd_i.res_we) begin
      res_status_q <= cmd_i.res_status;
      if (cmd_i.res_status != scsa_pkg::ST_OK) res_addr_q <= '0;
      else if (req_type_q) res_addr_q <= free_addr_q;
      else res_addr_q <= pop_addr;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
    end
  end

  // Slot link memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.claim_step) slot_link_mem[{new_page_q, slot_ctr_q}] <= build_head_q;
    else if (cmd_i.free_commit) slot_link_mem[{fp, fslot}] <= page_head_q[fp];
    if (cmd_i.walk_read) link_rd_q <= slot_link_mem[{cur_page_q, page_head_q[cur_page_q]}];
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign object_address_o = out_addr_q;

endmodule

[hw/rtl/size_class_slab_allocator_unit.sv]
// Top level of the power-of-two size-class slab allocator.
// Takes allocate or free requests one at a time and answers each with one
// status and address. A free, or an allocate that fails its size check, goes
// from decode straight to the result register and then the output register.
// An allocate from a class with free objects loads the class list head, walks
// past pages with no free slot (at most 16) and pops a slot. An allocate that
// must claim a fresh page first links its 4096 / class_size - 1 free slots into
// a list, one slot per cycle through the slot link memory's single write port.
// The next request is taken once the result sits in the output register.
module size_class_slab_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [12:0] req_size_i,
  input  logic [15:0] free_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] object_address_o
);

  scsa_pkg::cmd_t  cmd;
  scsa_pkg::stat_t stat;

  // Sequence each request through decode, page claim, list walk and pop.
  scsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold all allocator state and the output register.
  scsa_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_type_i       (req_type_i),
    .req_size_i       (req_size_i),
    .free_address_i   (free_address_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .object_address_o (object_address_o),
    .cmd_i            (cmd),
    .stat_o           (stat)
  );

  // An accepted request keeps the input side closed in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after accept");

  // Any error result carries address zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != scsa_pkg::ST_OK) |-> (object_address_o == 16'd0))
    else $error("error result with nonzero address");

  // Only one result per request: a new result needs a finished request first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_out) |-> !(in_valid_i && in_ready_o))
    else $error("result loaded while accepting");

endmodule
